FILE: rtl/qshp_pkg.sv
`timescale 1ns / 1ps

package qshp_pkg;

  // Fixed width of the value fields on both channels
  localparam int unsigned VALUE_W = 32;

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    ST_LOAD   = 13'b0000000000001,
    ST_START  = 13'b0000000000010,
    ST_POP    = 13'b0000000000100,
    ST_RNG    = 13'b0000000001000,
    ST_PIV    = 13'b0000000010000,
    ST_RDL    = 13'b0000000100000,
    ST_SCANL  = 13'b0000001000000,
    ST_SCANR  = 13'b0000010000000,
    ST_SWAP   = 13'b0000100000000,
    ST_PUSH_A = 13'b0001000000000,
    ST_PUSH_B = 13'b0010000000000,
    ST_EMIT0  = 13'b0100000000000,
    ST_EOUT   = 13'b1000000000000
  } qshp_state_t;

  // Which range goes onto the stack
  typedef enum logic [1:0] {
    PUSH_NONE  = 2'd0,
    PUSH_ALL   = 2'd1,
    PUSH_UPPER = 2'd2,
    PUSH_LOWER = 2'd3
  } qshp_push_t;

  typedef struct packed {
    logic       load;        // store input item, bump count
    qshp_push_t push;
    logic       pop;         // sp--, read stack top
    logic       rng_ld;      // take lo/hi from stack, read pivot
    logic       piv_ld;      // latch pivot, reset pointers
    logic       rd_left;     // read store at left
    logic       l_step;      // left++, read next
    logic       l_stop;      // hold left value, read at right
    logic       r_step;      // right--, read next
    logic       swap_left;   // store[left] <= right value
    logic       swap_right;  // store[right] <= left value, step both
    logic       emit_first;  // k <= 0, read store[0]
    logic       emit_next;   // k++, read store[k+1]
    logic       cnt_clr;     // clear count, back to empty
  } qshp_cmd_t;

  typedef struct packed {
    logic few;        // fewer than two elements held
    logic sp_zero;
    logic rng_empty;  // popped range has hi <= lo
    logic left_go;
    logic right_go;
    logic crossed;    // left >= right
    logic emit_end;   // current output is the last one
  } qshp_sts_t;

endpackage

FILE: rtl/qshp_ctrl.sv
`timescale 1ns / 1ps

module qshp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  qshp_pkg::qshp_sts_t sts,
  output qshp_pkg::qshp_cmd_t cmd
);

  qshp_pkg::qshp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qshp_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      qshp_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = qshp_pkg::ST_START;
          end
        end
      end
      qshp_pkg::ST_START: begin
        if (sts.few) begin
          state_nxt = qshp_pkg::ST_EMIT0;
        end else begin
          cmd.push  = qshp_pkg::PUSH_ALL;
          state_nxt = qshp_pkg::ST_POP;
        end
      end
      qshp_pkg::ST_POP: begin
        if (sts.sp_zero) begin
          state_nxt = qshp_pkg::ST_EMIT0;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = qshp_pkg::ST_RNG;
        end
      end
      qshp_pkg::ST_RNG: begin
        cmd.rng_ld = 1'b1;
        state_nxt  = sts.rng_empty ? qshp_pkg::ST_POP : qshp_pkg::ST_PIV;
      end
      qshp_pkg::ST_PIV: begin
        cmd.piv_ld = 1'b1;
        state_nxt  = qshp_pkg::ST_RDL;
      end
      qshp_pkg::ST_RDL: begin
        cmd.rd_left = 1'b1;
        state_nxt   = qshp_pkg::ST_SCANL;
      end
      qshp_pkg::ST_SCANL: begin
        if (sts.left_go) begin
          cmd.l_step = 1'b1;
        end else begin
          cmd.l_stop = 1'b1;
          state_nxt  = qshp_pkg::ST_SCANR;
        end
      end
      qshp_pkg::ST_SCANR: begin
        if (sts.right_go) begin
          cmd.r_step = 1'b1;
        end else if (sts.crossed) begin
          state_nxt = qshp_pkg::ST_PUSH_A;
        end else begin
          cmd.swap_left = 1'b1;
          state_nxt     = qshp_pkg::ST_SWAP;
        end
      end
      qshp_pkg::ST_SWAP: begin
        cmd.swap_right = 1'b1;
        state_nxt      = qshp_pkg::ST_RDL;
      end
      qshp_pkg::ST_PUSH_A: begin
        cmd.push  = qshp_pkg::PUSH_UPPER;
        state_nxt = qshp_pkg::ST_PUSH_B;
      end
      qshp_pkg::ST_PUSH_B: begin
        cmd.push  = qshp_pkg::PUSH_LOWER;
        state_nxt = qshp_pkg::ST_POP;
      end
      qshp_pkg::ST_EMIT0: begin
        cmd.emit_first = 1'b1;
        state_nxt      = qshp_pkg::ST_EOUT;
      end
      qshp_pkg::ST_EOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_end) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = qshp_pkg::ST_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = qshp_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: rtl/qshp_dp.sv
`timescale 1ns / 1ps

module qshp_dp #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [qshp_pkg::VALUE_W-1:0] in_value,
  output logic signed [qshp_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                                out_sorted_last,
  input  qshp_pkg::qshp_cmd_t                 cmd,
  output qshp_pkg::qshp_sts_t                 sts
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned STK_W = 2 * IDX_W;

  logic [DATA_WIDTH-1:0] store_mem [MAX_ITEMS];
  logic [STK_W-1:0]      stack_mem [MAX_ITEMS];

  logic [CNT_W-1:0]      count_r, sp_r;
  logic [IDX_W-1:0]      lo_r, hi_r, left_r, right_r, k_r;
  logic [DATA_WIDTH-1:0] pivot_r, lval_r, rdata_r;
  logic [STK_W-1:0]      srdata_r;

  logic [63:0]           in_ext, out_ext;
  logic [DATA_WIDTH-1:0] in_data;
  logic [CNT_W-1:0]      sp_dec, cnt_dec;
  logic [IDX_W-1:0]      stk_lo, stk_hi;

  logic                  rd_en, we;
  logic [IDX_W-1:0]      raddr, waddr;
  logic [DATA_WIDTH-1:0] wdata;

  logic                  push_ok;
  logic [IDX_W-1:0]      p_lo, p_hi;

  // Input is taken as its 32 raw bits; compare is signed at DATA_WIDTH
  assign in_ext  = {32'd0, in_value};
  assign in_data = in_ext[DATA_WIDTH-1:0];
  assign out_ext = 64'(rdata_r);
  assign out_sorted_value = out_ext[qshp_pkg::VALUE_W-1:0];

  assign sp_dec  = sp_r - CNT_W'(1);
  assign cnt_dec = count_r - CNT_W'(1);
  assign stk_lo  = srdata_r[STK_W-1:IDX_W];
  assign stk_hi  = srdata_r[IDX_W-1:0];

  // Store read port
  always_comb begin
    rd_en = 1'b1;
    raddr = left_r;
    if (cmd.rng_ld) begin
      raddr = stk_hi;
    end else if (cmd.rd_left) begin
      raddr = left_r;
    end else if (cmd.l_step) begin
      raddr = left_r + IDX_W'(1);
    end else if (cmd.l_stop) begin
      raddr = right_r;
    end else if (cmd.r_step) begin
      raddr = right_r - IDX_W'(1);
    end else if (cmd.emit_first) begin
      raddr = '0;
    end else if (cmd.emit_next) begin
      raddr = k_r + IDX_W'(1);
    end else begin
      rd_en = 1'b0;
    end
  end

  // Store write port
  always_comb begin
    we    = 1'b0;
    waddr = left_r;
    wdata = rdata_r;
    if (cmd.load) begin
      we    = count_r < CNT_W'(MAX_ITEMS);
      waddr = count_r[IDX_W-1:0];
      wdata = in_data;
    end else if (cmd.swap_left) begin
      we    = 1'b1;
      waddr = left_r;
      wdata = rdata_r;
    end else if (cmd.swap_right) begin
      we    = 1'b1;
      waddr = right_r;
      wdata = lval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= store_mem[raddr];
    end
  end

  // Range push, ranges of fewer than two elements and overflow ranges dropped
  always_comb begin
    p_lo    = lo_r;
    p_hi    = hi_r;
    push_ok = 1'b0;
    case (cmd.push)
      qshp_pkg::PUSH_ALL: begin
        p_lo    = '0;
        p_hi    = cnt_dec[IDX_W-1:0];
        push_ok = cnt_dec[IDX_W-1:0] > p_lo;
      end
      qshp_pkg::PUSH_UPPER: begin
        p_lo    = left_r;
        p_hi    = hi_r;
        push_ok = hi_r > left_r;
      end
      qshp_pkg::PUSH_LOWER: begin
        p_lo    = lo_r;
        p_hi    = left_r - IDX_W'(1);
        push_ok = (left_r > lo_r) && ((left_r - IDX_W'(1)) > lo_r);
      end
      default: begin
        push_ok = 1'b0;
      end
    endcase
    push_ok = push_ok && (sp_r < CNT_W'(MAX_ITEMS));
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[sp_r[IDX_W-1:0]] <= {p_lo, p_hi};
    end
    if (cmd.pop) begin
      srdata_r <= stack_mem[sp_dec[IDX_W-1:0]];
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sp_r    <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.load && (count_r < CNT_W'(MAX_ITEMS))) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (push_ok) begin
        sp_r <= sp_r + CNT_W'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_dec;
      end
    end
  end

  // Partition and emit registers
  always_ff @(posedge clk) begin
    if (cmd.rng_ld) begin
      lo_r <= stk_lo;
      hi_r <= stk_hi;
    end
    if (cmd.piv_ld) begin
      pivot_r <= rdata_r;
    end
    if (cmd.l_stop) begin
      lval_r <= rdata_r;
    end
    if (cmd.piv_ld) begin
      left_r  <= lo_r;
      right_r <= hi_r;
    end else if (cmd.l_step) begin
      left_r <= left_r + IDX_W'(1);
    end else if (cmd.r_step) begin
      right_r <= right_r - IDX_W'(1);
    end else if (cmd.swap_right) begin
      left_r  <= left_r + IDX_W'(1);
      right_r <= right_r - IDX_W'(1);
    end
    if (cmd.emit_first) begin
      k_r <= '0;
    end else if (cmd.emit_next) begin
      k_r <= k_r + IDX_W'(1);
    end
  end

  always_comb begin
    sts.few       = count_r < CNT_W'(2);
    sts.sp_zero   = (sp_r == '0);
    sts.rng_empty = stk_hi <= stk_lo;
    sts.left_go   = (left_r < hi_r) && ($signed(rdata_r) < $signed(pivot_r));
    sts.right_go  = (right_r > lo_r) && ($signed(rdata_r) > $signed(pivot_r));
    sts.crossed   = left_r >= right_r;
    sts.emit_end  = (CNT_W'(k_r) == cnt_dec);
  end

  assign out_sorted_last = sts.emit_end;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond store depth");

  a_stack_bound : assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(MAX_ITEMS))
    else $error("range stack overflow");

  a_swap_order : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_left |-> left_r < right_r)
    else $error("swap on crossed pointers");

  a_swap_pair : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_left |=> cmd.swap_right && $stable(right_r))
    else $error("swap half not completed");

endmodule

FILE: rtl/quicksort_hoare_partition.sv
`timescale 1ns / 1ps

// Quicksort with Hoare partitioning. Items (value, last) are written into a
// local store, one per cycle; the item flagged last closes the set and
// starts the sort (items beyond MAX_ITEMS are dropped, though a dropped last
// item still starts it). Each range takes its last element as pivot, the
// left pointer becomes the split, and pending ranges sit on an explicit
// stack. The sorted set then streams out ascending, one item per cycle while
// out_ready is high, with out_sorted_last on the greatest. A set of one
// item comes back unchanged. Values are held as DATA_WIDTH-bit two's
// complement (the low bits of in_value) and returned zero-extended to 32
// bits. The sort is paced by the single read port of the element store: a
// popped range passes the pop, range-load and pivot-load states, and then
// each pointer step, each halt of a scan (the right-hand halt also writes
// the first half of a swap unless the pointers have crossed), the finish
// of a swap, the reread of the left element and the push of each of the
// two sub-ranges is a step of its own. in_ready is low from the last item
// in until the last result has been taken.

module quicksort_hoare_partition #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qshp_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qshp_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                                out_sorted_last
);

  qshp_pkg::qshp_cmd_t cmd;
  qshp_pkg::qshp_sts_t sts;

  // Sequencer: load, partition loop, stack walk, emit
  qshp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Element store, range stack, pointers and compare
  qshp_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .out_sorted_value (out_sorted_value),
    .out_sorted_last  (out_sorted_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
